[hdl/sfd_pkg.sv]
// Shared types, constants and the CRC step function for the stuffed frame deframer.
`default_nettype none
package sfd_pkg;

    localparam int MAX_FRAME = 1024;
    localparam int COUNT_W = $clog2(MAX_FRAME + 1);
    localparam int PLEN_W = 11;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] MARK_START = 8'hFC;
    localparam logic [7:0] MARK_END = 8'hFD;
    localparam logic [7:0] MARK_ESC = 8'hFE;
    localparam logic [7:0] ESC_XOR = 8'h20;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_CRC = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_ABORT = 3'd3;
    localparam logic [2:0] ST_OVER = 3'd4;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_OPEN_ABORT,
        OP_DATA,
        OP_END,
        OP_ABORT,
        OP_OVER
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } token_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] x);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]} ^ {8'h00, x};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/sfd_front.sv]
// Front end: frame hunting, unstuffing and classification of line bytes into tokens.
`default_nettype none
module sfd_front
    import sfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    output token_t            token,
    output logic              push
);

    logic               in_frame_reg;
    logic               in_frame_next;
    logic               escape_reg;
    logic               escape_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         plain;
    logic               is_data;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        escape_next = escape_reg;
        count_next = count_reg;
        push = 1'b0;
        is_data = 1'b0;
        plain = in_byte;
        token.op = OP_DATA;
        token.value = in_byte;
        if (in_byte == MARK_START)
        begin
            push = 1'b1;
            token.op = in_frame_reg ? OP_OPEN_ABORT : OP_OPEN;
            in_frame_next = 1'b1;
            escape_next = 1'b0;
            count_next = '0;
        end
        else if (in_frame_reg)
        begin
            if (escape_reg)
            begin
                escape_next = 1'b0;
                if (in_byte == MARK_END)
                begin
                    push = 1'b1;
                    token.op = OP_ABORT;
                    in_frame_next = 1'b0;
                end
                else
                begin
                    plain = in_byte ^ ESC_XOR;
                    is_data = 1'b1;
                end
            end
            else if (in_byte == MARK_ESC)
            begin
                escape_next = 1'b1;
            end
            else if (in_byte == MARK_END)
            begin
                push = 1'b1;
                token.op = OP_END;
                in_frame_next = 1'b0;
            end
            else
            begin
                is_data = 1'b1;
            end
        end
        if (is_data)
        begin
            push = 1'b1;
            token.value = plain;
            if (count_reg >= COUNT_W'(MAX_FRAME))
            begin
                token.op = OP_OVER;
                in_frame_next = 1'b0;
            end
            else
            begin
                token.op = OP_DATA;
                count_next = count_reg + COUNT_W'(1);
            end
        end
        push = push & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            escape_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            in_frame_reg <= in_frame_next;
            escape_reg <= escape_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[hdl/sfd_queue.sv]
// Short token queue between the front end and the back end.
`default_nettype none
module sfd_queue
    import sfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t token_in,
    output logic        full,
    output logic        valid,
    output token_t      token_out,
    input  wire logic   pop
);

    token_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full = (count_reg == QCNT_W'(QDEPTH));
    assign valid = (count_reg != '0);
    assign token_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[hdl/sfd_back.sv]
// Back end: delay line, CRC check, header capture and the result register.
`default_nettype none
module sfd_back
    import sfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          tok_valid,
    input  wire token_t        tok,
    output logic               tok_pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [1:0]         kind,
    output logic [7:0]         data,
    output logic [7:0]         packet_number,
    output logic [15:0]        packet_code,
    output logic [2:0]         status,
    output logic [PLEN_W-1:0]  payload_length,
    output logic               last
);

    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         number_reg;
    logic [7:0]         number_next;
    logic [15:0]        code_reg;
    logic [15:0]        code_next;
    logic [7:0]         delay0_reg;
    logic [7:0]         delay1_reg;
    logic               shift;

    logic               valid_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         data_reg;
    logic [7:0]         number_out_reg;
    logic [15:0]        code_out_reg;
    logic [2:0]         status_reg;
    logic [PLEN_W-1:0]  plen_reg;
    logic               last_reg;

    logic               advance;
    logic               emit;
    logic [1:0]         e_kind;
    logic [7:0]         e_data;
    logic [2:0]         e_status;
    logic               e_end;
    logic [PLEN_W-1:0]  emitted;

    assign advance = !valid_reg || !result_stall;
    assign tok_pop = tok_valid && advance;
    assign emitted = (count_reg >= COUNT_W'(5)) ? PLEN_W'(count_reg - COUNT_W'(5)) : '0;

    always_comb
    begin
        crc_next = crc_reg;
        count_next = count_reg;
        number_next = number_reg;
        code_next = code_reg;
        shift = 1'b0;
        emit = 1'b0;
        e_kind = KIND_END;
        e_data = 8'h00;
        e_status = ST_OK;
        e_end = 1'b0;
        unique case (tok.op)
            OP_OPEN, OP_OPEN_ABORT:
            begin
                emit = (tok.op == OP_OPEN_ABORT);
                e_end = 1'b1;
                e_status = ST_ABORT;
                crc_next = CRC_INIT;
                count_next = '0;
                number_next = 8'h00;
                code_next = 16'h0000;
            end
            OP_ABORT:
            begin
                emit = 1'b1;
                e_end = 1'b1;
                e_status = ST_ABORT;
            end
            OP_OVER:
            begin
                emit = 1'b1;
                e_end = 1'b1;
                e_status = ST_OVER;
            end
            OP_END:
            begin
                emit = 1'b1;
                e_end = 1'b1;
                if (count_reg < COUNT_W'(5))
                begin
                    e_status = ST_SHORT;
                end
                else if ({delay1_reg, delay0_reg} != crc_reg)
                begin
                    e_status = ST_CRC;
                end
                else
                begin
                    e_status = ST_OK;
                end
            end
            OP_DATA:
            begin
                shift = 1'b1;
                count_next = count_reg + COUNT_W'(1);
                if (count_reg >= COUNT_W'(2))
                begin
                    crc_next = crc_step(crc_reg, delay0_reg);
                    if (count_reg == COUNT_W'(2))
                    begin
                        number_next = delay0_reg;
                    end
                    else if (count_reg == COUNT_W'(3))
                    begin
                        code_next = {8'h00, delay0_reg};
                    end
                    else if (count_reg == COUNT_W'(4))
                    begin
                        code_next = {delay0_reg, code_reg[7:0]};
                        emit = 1'b1;
                        e_kind = KIND_HEADER;
                    end
                    else
                    begin
                        emit = 1'b1;
                        e_kind = KIND_PAYLOAD;
                        e_data = delay0_reg;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            count_reg <= '0;
            number_reg <= 8'h00;
            code_reg <= 16'h0000;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_pop && emit;
            if (tok_pop)
            begin
                crc_reg <= crc_next;
                count_reg <= count_next;
                number_reg <= number_next;
                code_reg <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && shift)
        begin
            delay0_reg <= delay1_reg;
            delay1_reg <= tok.value;
        end
        if (tok_pop)
        begin
            if (e_end)
            begin
                kind_reg <= KIND_END;
                data_reg <= 8'h00;
                number_out_reg <= number_reg;
                code_out_reg <= code_reg;
                status_reg <= e_status;
                plen_reg <= emitted;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= e_kind;
                data_reg <= e_data;
                number_out_reg <= (e_kind == KIND_HEADER) ? number_next : 8'h00;
                code_out_reg <= (e_kind == KIND_HEADER) ? code_next : 16'h0000;
                status_reg <= ST_OK;
                plen_reg <= '0;
                last_reg <= 1'b0;
            end
        end
    end

    assign result_valid = valid_reg;
    assign kind = kind_reg;
    assign data = data_reg;
    assign packet_number = number_out_reg;
    assign packet_code = code_out_reg;
    assign status = status_reg;
    assign payload_length = plen_reg;
    assign last = last_reg;

endmodule
`default_nettype wire

[hdl/stuffed_frame_deframer_crc16_top.sv]
// Top level of the byte-stuffed frame deframer with CRC-16 check.
// The block takes one received line byte per transaction and sustains one byte per clock
// cycle. The front end classifies and unstuffs each accepted byte into a two-entry token
// queue; the back end pops the token, updates the delay line, CRC and counters, and loads
// the result register. The byte input stalls only while the token queue is full, which
// happens when the result side stalls. A frame of five or more bytes gives a header result,
// one result per payload byte and one end result carrying the status and payload length;
// a shorter frame gives only the end result, and bytes outside a frame give no result.
`default_nettype none
module stuffed_frame_deframer_crc16_top
    import sfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_stall,
    input  wire logic [7:0]    in_byte,
    output logic               result_valid,
    input  wire logic          result_stall,
    output logic [1:0]         kind,
    output logic [7:0]         data,
    output logic [7:0]         packet_number,
    output logic [15:0]        packet_code,
    output logic [2:0]         status,
    output logic [PLEN_W-1:0]  payload_length,
    output logic               last
);

    token_t front_token;
    token_t queue_token;
    logic   front_push;
    logic   queue_full;
    logic   queue_valid;
    logic   queue_pop;
    logic   accept;

    assign byte_stall = queue_full;
    assign accept = byte_valid && !queue_full;

    sfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .token   (front_token),
        .push    (front_push)
    );

    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .token_in  (front_token),
        .full      (queue_full),
        .valid     (queue_valid),
        .token_out (queue_token),
        .pop       (queue_pop)
    );

    sfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_valid      (queue_valid),
        .tok            (queue_token),
        .tok_pop        (queue_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data           (data),
        .packet_number  (packet_number),
        .packet_code    (packet_code),
        .status         (status),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule
`default_nettype wire
